// File: sv/forward_difference_contour_macros.svh
// Assertion helpers; they expect clk_i and rst_ni in the scope of use.
`ifndef FORWARD_DIFFERENCE_CONTOUR_MACROS_SVH
`define FORWARD_DIFFERENCE_CONTOUR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fdc_pkg.sv
package fdc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_HEIGHT     = 1024;

  localparam int ROW_W   = 10;  // row counter, holds 0..MAX_HEIGHT-1
  localparam int POS_W   = 10;  // out_row / out_col port width
  localparam int SIZE_W  = 11;  // image_width / image_height registers
  localparam int GREY_W  = 16;  // max_grey register
  localparam int OUT_W   = 16;  // out_value and pixel_value ports
  localparam int ADDR_W  = 4;   // APB byte address
  localparam int DATA_W  = 32;  // APB data

  localparam int NUM_SLOTS = 3;
  localparam int SLOT_UP   = 0;  // row above, same column
  localparam int SLOT_LEFT = 1;  // last row, one column behind
  localparam int SLOT_LAST = 2;  // final pixel of the frame

  localparam logic [SIZE_W-1:0] WIDTH_RST    = 11'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RST   = 11'd1024;
  localparam logic [GREY_W-1:0] MAX_GREY_RST = 16'd255;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_MAX_GREY = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [GREY_W-1:0] max_grey;
    logic              restart;
  } fdc_cfg_t;

  typedef struct packed {
    logic has_up;     // a row above exists
    logic last_row;
    logic col_nz;     // column is not the first
    logic last_col;
    logic has_right;  // a right neighbour exists
  } fdc_flags_t;

endpackage

// File: sv/fdc_ram.sv
module fdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/fdc_cfg.sv
module fdc_cfg
  import fdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output fdc_cfg_t          cfg_o
);

  logic [SIZE_W-1:0] width_q, width_d;
  logic [SIZE_W-1:0] height_q, height_d;
  logic [GREY_W-1:0] max_grey_q, max_grey_d;
  logic              wr;
  logic              hit;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    max_grey_d = max_grey_q;
    hit        = 1'b0;
    prdata     = '0;
    unique case (idx)
      REG_WIDTH: begin
        prdata = DATA_W'(width_q);
        if (wr) begin
          width_d = pwdata[SIZE_W-1:0];
          hit     = 1'b1;
        end
      end
      REG_HEIGHT: begin
        prdata = DATA_W'(height_q);
        if (wr) begin
          height_d = pwdata[SIZE_W-1:0];
          hit      = 1'b1;
        end
      end
      REG_MAX_GREY: begin
        prdata = DATA_W'(max_grey_q);
        if (wr) begin
          max_grey_d = pwdata[GREY_W-1:0];
          hit        = 1'b1;
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      max_grey_q <= MAX_GREY_RST;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      max_grey_q <= max_grey_d;
    end
  end

  // A write to a known register restarts the frame in the same cycle.
  assign cfg_o.width    = width_q;
  assign cfg_o.height   = height_q;
  assign cfg_o.max_grey = max_grey_q;
  assign cfg_o.restart  = hit;

endmodule

// File: sv/fdc_line.sv
module fdc_line
  import fdc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fdc_cfg_t              cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  input  logic                  advance_i,
  output logic                  a_valid_o,
  output logic [PIXEL_BITS-1:0] a_pix_o,
  output logic [PIXEL_BITS-1:0] a_prev_o,
  output logic [PIXEL_BITS-1:0] a_up_o,
  output logic [PIXEL_BITS-1:0] a_right_o,
  output logic [ROW_W-1:0]      a_row_o,
  output logic [CW-1:0]         a_col_o,
  output fdc_flags_t            a_flags_o
);

  logic [CW-1:0]         col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [PIXEL_BITS-1:0] prev_q;
  logic [PIXEL_BITS-1:0] row0_q;
  logic                  a_valid_q;
  logic [PIXEL_BITS-1:0] a_pix_q, a_prev_q, a_up_q;
  logic [ROW_W-1:0]      a_row_q;
  logic [CW-1:0]         a_col_q;
  fdc_flags_t            a_flags_q;

  logic [WW-1:0]         w_eff;
  logic [SIZE_W-1:0]     h_eff;
  logic [WW-1:0]         col_p1;
  logic [SIZE_W-1:0]     row_p1;
  fdc_flags_t            flags;
  logic                  accept;
  logic [PIXEL_BITS-1:0] ram_rdata;

  assign in_ready_o = !a_valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (cfg_i.width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_i.width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_i.width);
    end
    if (cfg_i.height == '0) begin
      h_eff = SIZE_W'(1);
    end else if (32'(cfg_i.height) > 32'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_i.height;
    end
  end

  assign col_p1 = WW'(col_q) + WW'(1);
  assign row_p1 = SIZE_W'(row_q) + SIZE_W'(1);

  assign flags.has_up    = (row_q != '0);
  assign flags.last_row  = (row_p1 == h_eff);
  assign flags.col_nz    = (col_q != '0);
  assign flags.last_col  = (col_p1 == w_eff);
  assign flags.has_right = (col_p1 < w_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_i.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (flags.last_col) begin
        col_d = '0;
        row_d = flags.last_row ? '0 : row_p1[ROW_W-1:0];
      end else begin
        col_d = col_p1[CW-1:0];
      end
    end
  end

  // Write this pixel at its column and fetch the old right neighbour; the
  // read data then holds until the next transaction, so it stays good for
  // the item in stage A and becomes the next item's upper pixel.
  fdc_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (pixel_i),
    .re_i    (accept && flags.has_right),
    .raddr_i (col_p1[CW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      prev_q    <= '0;
      a_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        prev_q    <= pixel_i;
        a_valid_q <= 1'b1;
      end else if (advance_i) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix_q   <= pixel_i;
      a_prev_q  <= prev_q;
      a_up_q    <= flags.col_nz ? ram_rdata : row0_q;
      a_row_q   <= row_q;
      a_col_q   <= col_q;
      a_flags_q <= flags;
      if (!flags.col_nz) begin
        row0_q <= pixel_i;
      end
    end
  end

  assign a_valid_o = a_valid_q;
  assign a_pix_o   = a_pix_q;
  assign a_prev_o  = a_prev_q;
  assign a_up_o    = a_up_q;
  assign a_right_o = ram_rdata;
  assign a_row_o   = a_row_q;
  assign a_col_o   = a_col_q;
  assign a_flags_o = a_flags_q;

endmodule

// File: sv/fdc_out.sv
module fdc_out
  import fdc_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int CW         = $clog2(MAX_WIDTH_DEF)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [GREY_W-1:0]     max_grey_i,
  input  logic                  a_valid_i,
  input  logic [PIXEL_BITS-1:0] a_pix_i,
  input  logic [PIXEL_BITS-1:0] a_prev_i,
  input  logic [PIXEL_BITS-1:0] a_up_i,
  input  logic [PIXEL_BITS-1:0] a_right_i,
  input  logic [ROW_W-1:0]      a_row_i,
  input  logic [CW-1:0]         a_col_i,
  input  fdc_flags_t            a_flags_i,
  output logic                  advance_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_W-1:0]      out_row_o,
  output logic [POS_W-1:0]      out_col_o,
  output logic [OUT_W-1:0]      out_value_o,
  output logic                  run_last_o,
  output logic                  frame_done_o
);

  function automatic logic [PIXEL_BITS-1:0] absdiff(input logic [PIXEL_BITS-1:0] a,
                                                     input logic [PIXEL_BITS-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [OUT_W-1:0] pick(input logic [PIXEL_BITS-1:0] orig,
                                            input logic [PIXEL_BITS-1:0] dx,
                                            input logic [PIXEL_BITS-1:0] dy,
                                            input logic [GREY_W-1:0]     maxg);
    logic [PIXEL_BITS:0] s;
    s = {1'b0, dx} + {1'b0, dy};
    return (32'(s) <= 32'(maxg)) ? OUT_W'(s) : OUT_W'(orig);
  endfunction

  logic [NUM_SLOTS-1:0] mask_q, mask_d;
  logic [OUT_W-1:0]     val_q [NUM_SLOTS];
  logic [OUT_W-1:0]     val_d [NUM_SLOTS];
  logic [ROW_W-1:0]     row_q;
  logic [CW-1:0]        col_q;
  logic                 b_free;
  logic [PIXEL_BITS-1:0] dx_up;
  logic [ROW_W-1:0]     row_sel;
  logic [CW-1:0]        col_sel;

  assign out_valid_o = (mask_q != '0);
  assign b_free      = !out_valid_o || (out_ready_i && $onehot(mask_q));
  assign advance_o   = a_valid_i && b_free;

  assign dx_up = a_flags_i.has_right ? absdiff(a_right_i, a_up_i) : a_up_i;

  always_comb begin
    val_d[SLOT_UP]   = pick(a_up_i, dx_up, absdiff(a_pix_i, a_up_i), max_grey_i);
    val_d[SLOT_LEFT] = pick(a_prev_i, absdiff(a_pix_i, a_prev_i), a_prev_i, max_grey_i);
    val_d[SLOT_LAST] = pick(a_pix_i, a_pix_i, a_pix_i, max_grey_i);
  end

  always_comb begin
    mask_d = mask_q;
    if (advance_o) begin
      mask_d[SLOT_UP]   = a_flags_i.has_up;
      mask_d[SLOT_LEFT] = a_flags_i.last_row && a_flags_i.col_nz;
      mask_d[SLOT_LAST] = a_flags_i.last_row && a_flags_i.last_col;
    end else if (out_valid_o && out_ready_i) begin
      // drop the slot just sent
      mask_d = mask_q & (mask_q - NUM_SLOTS'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      val_q <= val_d;
      row_q <= a_row_i;
      col_q <= a_col_i;
    end
  end

  always_comb begin
    row_sel      = row_q;
    col_sel      = col_q;
    out_value_o  = val_q[SLOT_LAST];
    frame_done_o = 1'b0;
    if (mask_q[SLOT_UP]) begin
      row_sel     = row_q - ROW_W'(1);
      out_value_o = val_q[SLOT_UP];
    end else if (mask_q[SLOT_LEFT]) begin
      col_sel     = col_q - CW'(1);
      out_value_o = val_q[SLOT_LEFT];
    end else begin
      frame_done_o = mask_q[SLOT_LAST];
    end
  end

  assign out_row_o  = POS_W'(row_sel);
  assign out_col_o  = POS_W'(col_sel);
  assign run_last_o = $onehot(mask_q);

endmodule

// File: sv/forward_difference_contour.sv
// Forward-difference contour filter, L1 gradient over a grey image.
// Input: pixel_value_i in raster order on in_valid_i/in_ready_o; only the
// low PIXEL_BITS bits are used. Output: one result per transaction on
// out_valid_o/out_ready_i with row, column, value, run_last and frame_done.
// The user must set image size and max grey over the APB port only while the
// block is idle; the block does not enforce this; any write to a known
// register restarts the frame at row 0, column 0. Pixel (i,j) above the last
// row comes out once pixel (i+1,j) leaves stage A. On the last row each pixel
// yields up to two results (three for the final pixel), so input there waits
// while they drain; other rows run at one pixel per cycle. The rate is set by
// the single result register: stage A holds one pixel while the results ahead
// of it drain one per cycle. The line store is one RAM with one write and one
// read port: each pixel writes its column and reads the right neighbour, if
// any; the upper pixel is the previous read, or a column-0 register. Reset
// clears the counters and handshakes; the line store is not cleared and needs
// no clearing pass. A stalled receiver holds the result buffer and
// back-pressures the input after one more pixel enters stage A.
`include "forward_difference_contour_macros.svh"

module forward_difference_contour
  import fdc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OUT_W-1:0]  pixel_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [POS_W-1:0]  out_row_o,
  output logic [POS_W-1:0]  out_col_o,
  output logic [OUT_W-1:0]  out_value_o,
  output logic              run_last_o,
  output logic              frame_done_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  fdc_cfg_t              cfg;
  logic                  advance;
  logic                  a_valid;
  logic [PIXEL_BITS-1:0] a_pix, a_prev, a_up, a_right;
  logic [ROW_W-1:0]      a_row;
  logic [CW-1:0]         a_col;
  fdc_flags_t            a_flags;

  fdc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fdc_line #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_value_i[PIXEL_BITS-1:0]),
    .advance_i  (advance),
    .a_valid_o  (a_valid),
    .a_pix_o    (a_pix),
    .a_prev_o   (a_prev),
    .a_up_o     (a_up),
    .a_right_o  (a_right),
    .a_row_o    (a_row),
    .a_col_o    (a_col),
    .a_flags_o  (a_flags)
  );

  fdc_out #(
    .PIXEL_BITS (PIXEL_BITS),
    .CW         (CW)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_grey_i   (cfg.max_grey),
    .a_valid_i    (a_valid),
    .a_pix_i      (a_pix),
    .a_prev_i     (a_prev),
    .a_up_i       (a_up),
    .a_right_i    (a_right),
    .a_row_i      (a_row),
    .a_col_i      (a_col),
    .a_flags_i    (a_flags),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_value_o  (out_value_o),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o)
  );

  `FDC_ASSERT_NEXT(a_accept_loads, in_valid_i && in_ready_o, a_valid, "accepted pixel missing in stage A")
  `FDC_ASSERT_SAME(a_done_is_last, out_valid_o && frame_done_o, run_last_o, "frame end is not the last result")
  `FDC_ASSERT_NEXT(a_run_continues, out_valid_o && !run_last_o, out_valid_o, "result run cut short")

endmodule

// File: sim/tb_top.sv
module tb_top;
  import fdc_pkg::*;

  localparam int REG_UNUSED = 3;  // no register at this index

  typedef enum int unsigned {
    PIX_ANY,
    PIX_NEAR,
    PIX_RAIL
  } pix_mode_e;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [OUT_W-1:0] value;
    logic             run_last;
    logic             frame_done;
  } contour_px_t;

  // Tracks the filter state and queues the contour pixels each input should produce.
  class contour_tracker;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [GREY_W-1:0] grey_reg;
    logic [OUT_W-1:0]  line_buf [MAX_WIDTH_DEF];
    logic [OUT_W-1:0]  prev_px;
    int unsigned       row;
    int unsigned       col;
    contour_px_t       pending[$];
    int                errors;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      grey_reg   = MAX_GREY_RST;
      prev_px    = '0;
      row        = 0;
      col        = 0;
      errors     = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_WIDTH:    width_reg = data[SIZE_W-1:0];
        REG_HEIGHT:   height_reg = data[SIZE_W-1:0];
        REG_MAX_GREY: grey_reg = data[GREY_W-1:0];
        default:      return;
      endcase
      row = 0;
      col = 0;
    endfunction

    function logic [DATA_W-1:0] reg_value(int unsigned idx);
      case (idx)
        REG_WIDTH:  return DATA_W'(width_reg);
        REG_HEIGHT: return DATA_W'(height_reg);
        default:    return DATA_W'(grey_reg);
      endcase
    endfunction

    function logic [OUT_W-1:0] gap(logic [OUT_W-1:0] a, logic [OUT_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Keep the original pixel when the gradient sum exceeds max grey.
    function logic [OUT_W-1:0] choose(logic [OUT_W-1:0] orig, logic [OUT_W-1:0] dx,
                                      logic [OUT_W-1:0] dy);
      logic [OUT_W:0] s;
      s = {1'b0, dx} + {1'b0, dy};
      return (s <= {1'b0, grey_reg}) ? s[OUT_W-1:0] : orig;
    endfunction

    function contour_px_t at(int unsigned r, int unsigned c, logic [OUT_W-1:0] v,
                             logic done);
      contour_px_t px;
      px.row        = r[POS_W-1:0];
      px.col        = c[POS_W-1:0];
      px.value      = v;
      px.run_last   = 1'b0;
      px.frame_done = done;
      return px;
    endfunction

    function void take_pixel(logic [OUT_W-1:0] p);
      int unsigned      w;
      int unsigned      h;
      int unsigned      r;
      int unsigned      c;
      int unsigned      n;
      logic [OUT_W-1:0] up;
      logic [OUT_W-1:0] dx;
      contour_px_t      trio [3];
      w = width_reg;
      h = height_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      r = row;
      c = col;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      n = 0;
      if (r > 0) begin
        up = line_buf[c];
        dx = (c + 1 < w) ? gap(line_buf[c + 1], up) : up;
        trio[n] = at(r - 1, c, choose(up, dx, gap(p, up)), 1'b0);
        n++;
      end
      if (r == h - 1) begin
        if (c > 0) begin
          trio[n] = at(r, c - 1, choose(prev_px, gap(p, prev_px), prev_px), 1'b0);
          n++;
        end
        if (c == w - 1) begin
          trio[n] = at(r, c, choose(p, p, p), 1'b1);
          n++;
        end
      end
      if (n > 0) trio[n - 1].run_last = 1'b1;
      for (int i = 0; i < n; i++) pending.push_back(trio[i]);
      line_buf[c] = p;
      prev_px = p;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col = c;
      row = r;
    endfunction

    function void report_mismatch(string what, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
      errors++;
    endfunction

    function void match_pixel(contour_px_t got);
      contour_px_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none got row %0d col %0d value %0h",
                 $time, got.row, got.col, got.value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.row !== want.row) report_mismatch("out_row", want.row, got.row);
      if (got.col !== want.col) report_mismatch("out_col", want.col, got.col);
      if (got.value !== want.value) report_mismatch("out_value", want.value, got.value);
      if (got.run_last !== want.run_last)
        report_mismatch("run_last", want.run_last, got.run_last);
      if (got.frame_done !== want.frame_done)
        report_mismatch("frame_done", want.frame_done, got.frame_done);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic [OUT_W-1:0]  pixel;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  out_row;
  logic [POS_W-1:0]  out_col;
  logic [OUT_W-1:0]  out_value;
  logic              run_last;
  logic              frame_done;

  contour_tracker    tracker = new();
  bit                calm;
  int unsigned       sent;
  logic [OUT_W-1:0]  near_base;

  forward_difference_contour uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pixel_value_i(pixel),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .out_value_o  (out_value),
    .run_last_o   (run_last),
    .frame_done_o (frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.match_pixel({out_row, out_col, out_value, run_last, frame_done});
    out_ready <= calm || ($urandom_range(99) >= 14);
  end

  function automatic logic [OUT_W-1:0] make_pixel(pix_mode_e mode);
    case (mode)
      PIX_NEAR: return near_base + OUT_W'($urandom_range(40));
      PIX_RAIL: return $urandom_range(1) ? {OUT_W{1'b1}} : {OUT_W{1'b0}};
      default:  return OUT_W'($urandom());
    endcase
  endfunction

  task automatic send_pixel(input logic [OUT_W-1:0] v);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= v;
    do @(posedge clk); while (!in_ready);
    tracker.take_pixel(v);
    sent++;
  endtask

  task automatic play(input logic [OUT_W-1:0] vals[$]);
    foreach (vals[i]) send_pixel(vals[i]);
    in_valid <= 1'b0;
  endtask

  task automatic feed(input int unsigned count, input pix_mode_e mode);
    repeat (count) send_pixel(make_pixel(mode));
    in_valid <= 1'b0;
  endtask

  // Wait out outstanding results and any pixel still in flight.
  task automatic settle();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(input int unsigned idx, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    settle();
    apb_cycle(1'b1, ADDR_W'(idx * 4), data, rd);
    tracker.write_reg(idx, data);
    if (idx != REG_UNUSED) begin
      @(posedge clk);
      apb_cycle(1'b0, ADDR_W'(idx * 4), '0, rd);
      if (rd !== tracker.reg_value(idx))
        tracker.report_mismatch("prdata", tracker.reg_value(idx), rd);
    end
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned start;
    logic [GREY_W-1:0] mg;
    pix_mode_e mode;

    rst_n     = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    pixel     = '0;
    calm      = 1'b0;
    sent      = 0;
    near_base = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner pixel values, sums both under and over max grey
    set_reg(REG_WIDTH, 3);
    set_reg(REG_HEIGHT, 2);
    set_reg(REG_MAX_GREY, 255);
    play('{16'h0000, 16'hFFFF, 16'h5555, 16'd12, 16'd20, 16'd7});
    // max grey of zero: only a zero sum replaces
    set_reg(REG_MAX_GREY, 0);
    set_reg(REG_WIDTH, 2);
    play('{16'd5, 16'd5, 16'd5, 16'd9});
    // single row
    set_reg(REG_HEIGHT, 1);
    set_reg(REG_WIDTH, 4);
    set_reg(REG_MAX_GREY, 32'h0000_FFFF);
    play('{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF});
    // single column
    set_reg(REG_WIDTH, 1);
    set_reg(REG_HEIGHT, 3);
    set_reg(REG_MAX_GREY, 1);
    play('{16'd0, 16'd1, 16'd1});
    // zero sizes act as one pixel, two frames back to back
    set_reg(REG_WIDTH, 0);
    set_reg(REG_HEIGHT, 0);
    play('{16'd3, 16'd0});
    // unknown register index must not restart the frame
    set_reg(REG_WIDTH, 3);
    set_reg(REG_HEIGHT, 2);
    set_reg(REG_MAX_GREY, 255);
    play('{16'd40, 16'd50});
    set_reg(REG_UNUSED, 1);
    play('{16'd45, 16'd60, 16'd30, 16'd52, 16'd100, 16'd110});
    // known register mid-frame restarts at row 0
    set_reg(REG_MAX_GREY, 300);
    play('{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6});

    // oversize and full-size registers, partial frames only
    set_reg(REG_WIDTH, 11'h7FF);
    set_reg(REG_HEIGHT, 1);
    feed(30, PIX_ANY);
    set_reg(REG_WIDTH, 0);
    set_reg(REG_HEIGHT, 11'h7FF);
    near_base = 16'd1000;
    feed(20, PIX_NEAR);
    set_reg(REG_WIDTH, 1024);
    set_reg(REG_HEIGHT, 1);
    feed(20, PIX_NEAR);
    set_reg(REG_WIDTH, 1);
    set_reg(REG_HEIGHT, 1024);
    feed(20, PIX_RAIL);

    start = sent;
    while (sent - start < 150) begin
      calm = (sent - start >= 50) && (sent - start < 110);
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(7, 40);
        h = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 5);
      end
      case ($urandom_range(3))
        0: mg = GREY_W'($urandom());
        1: mg = {GREY_W{1'b1}};
        2: mg = GREY_W'($urandom_range(64));
        default: mg = 16'd255;
      endcase
      // junk above the register width must be dropped
      if ($urandom_range(1)) begin
        set_reg(REG_HEIGHT, {21'($urandom()), SIZE_W'(h)});
        set_reg(REG_WIDTH, {21'($urandom()), SIZE_W'(w)});
      end else begin
        set_reg(REG_WIDTH, {21'($urandom()), SIZE_W'(w)});
        set_reg(REG_HEIGHT, {21'($urandom()), SIZE_W'(h)});
      end
      if ($urandom_range(9) < 6) set_reg(REG_MAX_GREY, {16'($urandom()), mg});
      near_base = $urandom_range(1) ? OUT_W'($urandom()) : OUT_W'($urandom_range(100));
      mode = pix_mode_e'($urandom_range(2));
      // some frames are cut short by the next register write
      if ($urandom_range(4) == 0) feed($urandom_range(1, w * h), mode);
      else feed($urandom_range(1, 3) * w * h, mode);
    end

    calm = 1'b0;
    settle();
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
